@@ sv/cttab_pkg.sv @@
// ----------------------------------------------------------------------------
// cttab_pkg
// Types and constants shared by the connection tuple table modules.
// ----------------------------------------------------------------------------
package cttab_pkg;

    localparam int KEY_W      = 96;
    localparam int DUMP_LIMIT = 32;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_UPDATE = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_DUMP   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic cmp;
        logic exec;
        logic dump_emit;
        logic dump_last;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic dump_go;
        logic dump_end;
    } t_dp_status;

endpackage

@@ sv/cttab_ctrl.sv @@
// ----------------------------------------------------------------------------
// cttab_ctrl
// Sequencer: compare cycle, execute cycle, then, for a non-empty dump, a dump state that emits the entries in order.
// ----------------------------------------------------------------------------
module cttab_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cttab_pkg::t_dp_status i_dp_status,
    output cttab_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_DUMP
    } t_state;

    t_state r_state;
    logic   accept;

    // the execute cycle takes a new word unless a dump follows
    always_comb begin
        busy = (r_state == S_CMP) || (r_state == S_DUMP) ||
               ((r_state == S_EXEC) && i_dp_status.dump_go);
        accept = start && !busy;
        o_cmd.load      = accept;
        o_cmd.cmp       = (r_state == S_CMP);
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.dump_emit = (r_state == S_DUMP);
        o_cmd.dump_last = (r_state == S_DUMP) && i_dp_status.dump_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (i_dp_status.dump_go) r_state <= S_DUMP;
                    else if (accept)         r_state <= S_CMP;
                    else                     r_state <= S_IDLE;
                end
                S_DUMP: begin
                    if (i_dp_status.dump_end) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/cttab_dpath.sv @@
// ----------------------------------------------------------------------------
// cttab_dpath
// Row of table cells with one key comparator each, packed entry storage,
// compaction on remove, and the result registers.
// ----------------------------------------------------------------------------
module cttab_dpath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cttab_pkg::t_ctrl_cmd   i_cmd,
    output cttab_pkg::t_dp_status  o_dp_status,
    input  logic                   i_cfg_wr_en,
    input  logic [7:0]             i_cfg_wr_data,
    input  logic [2:0]             i_operation,
    input  logic [31:0]            i_source_address,
    input  logic [31:0]            i_dest_address,
    input  logic [15:0]            i_source_port,
    input  logic [15:0]            i_dest_port,
    input  logic [7:0]             i_new_state,
    output logic                   o_result_valid,
    output logic [1:0]             o_status,
    output logic                   o_found,
    output logic [7:0]             o_state_value,
    output logic [31:0]            o_entry_source_address,
    output logic [31:0]            o_entry_dest_address,
    output logic [15:0]            o_entry_source_port,
    output logic [15:0]            o_entry_dest_port,
    output logic [6:0]             o_table_count,
    output logic                   o_last
);

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int DUMP_N = (TABLE_DEPTH < cttab_pkg::DUMP_LIMIT) ?
                            TABLE_DEPTH : cttab_pkg::DUMP_LIMIT;
    localparam int KW     = cttab_pkg::KEY_W;

    logic [2:0]             r_op;
    logic [KW-1:0]          r_key;
    logic [7:0]             r_new_state;
    logic [7:0]             r_closed;
    logic [CW-1:0]          r_count;
    logic [TABLE_DEPTH-1:0] r_match;
    logic [KW-1:0]          r_key_cell   [TABLE_DEPTH];
    logic [7:0]             r_state_cell [TABLE_DEPTH];
    logic [IW-1:0]          r_dump_idx;

    logic                   r_result_valid;
    logic [1:0]             r_status;
    logic                   r_found;
    logic [7:0]             r_state_value;
    logic [KW-1:0]          r_entry_key;
    logic [6:0]             r_table_count;
    logic                   r_last;

    logic                   hit;
    logic                   full;
    logic [7:0]             sel_state;
    logic [TABLE_DEPTH-1:0] above;
    logic                   upd;
    logic                   append;
    logic                   shift;
    logic [CW-1:0]          n_count;
    logic [1:0]             res_status;
    logic                   res_found;
    logic [7:0]             res_state;
    logic [CW-1:0]          dump_n;

    // ------------------------------------------------------------------
    // operation decode for the execute cycle
    // ------------------------------------------------------------------
    always_comb begin
        hit  = |r_match;
        full = (r_count == CW'(TABLE_DEPTH));
        sel_state = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            sel_state = sel_state | (r_state_cell[i] & {8{r_match[i]}});
        end
        // keys are unique, so the match is one-hot: mark it and all above
        above = ~(r_match - TABLE_DEPTH'(1));

        upd        = 1'b0;
        append     = 1'b0;
        shift      = 1'b0;
        n_count    = r_count;
        res_status = cttab_pkg::ST_DONE;
        res_found  = 1'b0;
        res_state  = '0;
        unique case (r_op)
            cttab_pkg::OP_ADD: begin
                if (hit) begin
                    upd       = 1'b1;
                    res_found = 1'b1;
                end else if (full) begin
                    res_status = cttab_pkg::ST_FULL;
                end else begin
                    append  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            cttab_pkg::OP_REMOVE: begin
                if (hit) begin
                    shift     = 1'b1;
                    res_found = 1'b1;
                    n_count   = r_count - CW'(1);
                end else begin
                    res_status = cttab_pkg::ST_NOT_FOUND;
                end
            end
            cttab_pkg::OP_UPDATE: begin
                if (hit) begin
                    upd       = 1'b1;
                    res_found = 1'b1;
                end else begin
                    res_status = cttab_pkg::ST_NOT_FOUND;
                end
            end
            cttab_pkg::OP_LOOKUP: begin
                if (hit) begin
                    res_found = 1'b1;
                    res_state = sel_state;
                end else begin
                    res_status = cttab_pkg::ST_NOT_FOUND;
                    res_state  = r_closed;
                end
            end
            cttab_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // dump of an empty table and unused codes: one plain word
            end
        endcase

        dump_n = (r_count > CW'(DUMP_N)) ? CW'(DUMP_N) : r_count;
        o_dp_status.dump_go  = (r_op == cttab_pkg::OP_DUMP) && (r_count != '0);
        o_dp_status.dump_end = ((CW'(r_dump_idx) + CW'(1)) == dump_n);
    end

    // ------------------------------------------------------------------
    // input latch, compare, configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_key       <= {i_source_address, i_dest_address, i_source_port, i_dest_port};
            r_new_state <= i_new_state;
        end
        if (i_cmd.cmp) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_match[i] <= (CW'(i) < r_count) && (r_key_cell[i] == r_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_wr_en) r_closed <= i_cfg_wr_data;
            if (i_cmd.exec)  r_count  <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // table cells: state write, append, shift down on remove
    // ------------------------------------------------------------------
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g < TABLE_DEPTH - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    if (shift && above[g] && ((CW'(g) + CW'(1)) < r_count)) begin
                        r_key_cell[g]   <= r_key_cell[g+1];
                        r_state_cell[g] <= r_state_cell[g+1];
                    end else if (append && (r_count == CW'(g))) begin
                        r_key_cell[g]   <= r_key;
                        r_state_cell[g] <= r_new_state;
                    end else if (upd && r_match[g]) begin
                        r_state_cell[g] <= r_new_state;
                    end
                end
            end
        end else begin : g_top
            always_ff @(posedge i_clk) begin
                if (i_cmd.exec) begin
                    if (append && (r_count == CW'(g))) begin
                        r_key_cell[g]   <= r_key;
                        r_state_cell[g] <= r_new_state;
                    end else if (upd && r_match[g]) begin
                        r_state_cell[g] <= r_new_state;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
            r_dump_idx     <= '0;
        end else begin
            r_result_valid <= (i_cmd.exec && !o_dp_status.dump_go) || i_cmd.dump_emit;
            if (i_cmd.exec)           r_dump_idx <= '0;
            else if (i_cmd.dump_emit) r_dump_idx <= r_dump_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !o_dp_status.dump_go) begin
            r_status      <= res_status;
            r_found       <= res_found;
            r_state_value <= res_state;
            r_entry_key   <= '0;
            r_table_count <= 7'(n_count);
            r_last        <= 1'b1;
        end else if (i_cmd.dump_emit) begin
            r_status      <= cttab_pkg::ST_DONE;
            r_found       <= 1'b1;
            r_state_value <= r_state_cell[r_dump_idx];
            r_entry_key   <= r_key_cell[r_dump_idx];
            r_table_count <= 7'(r_count);
            r_last        <= i_cmd.dump_last;
        end
    end

    assign o_result_valid         = r_result_valid;
    assign o_status               = r_status;
    assign o_found                = r_found;
    assign o_state_value          = r_state_value;
    assign o_entry_source_address = r_entry_key[95:64];
    assign o_entry_dest_address   = r_entry_key[63:32];
    assign o_entry_source_port    = r_entry_key[31:16];
    assign o_entry_dest_port      = r_entry_key[15:0];
    assign o_table_count          = r_table_count;
    assign o_last                 = r_last;

endmodule

@@ sv/connection_tuple_table_top.sv @@
// A word passes the input latch, the registered compare and the result registers.
// A new word is taken when idle or in the execute state of the word before it.
// A dump returns up to DUMP_LIMIT entries back to back in the dump state; busy holds.
// Pace is set by the registered compare over all cells followed by the write cycle.
// Reset (synchronous, active low) empties the table and sets the closed code to 0.
// Results carry a one-cycle strobe; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// connection_tuple_table_top
// Exact-match connection tracking table with add, remove, update, lookup,
// clear and dump.
// ----------------------------------------------------------------------------
module connection_tuple_table_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_dest_address,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [7:0]  i_new_state,
    output logic        o_result_valid,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [7:0]  o_state_value,
    output logic [31:0] o_entry_source_address,
    output logic [31:0] o_entry_dest_address,
    output logic [15:0] o_entry_source_port,
    output logic [15:0] o_entry_dest_port,
    output logic [6:0]  o_table_count,
    output logic        o_last
);

    cttab_pkg::t_ctrl_cmd  cmd;
    cttab_pkg::t_dp_status dp_status;

    cttab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    cttab_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_dp_status            (dp_status),
        .i_cfg_wr_en            (i_cfg_wr_en),
        .i_cfg_wr_data          (i_cfg_wr_data),
        .i_operation            (i_operation),
        .i_source_address       (i_source_address),
        .i_dest_address         (i_dest_address),
        .i_source_port          (i_source_port),
        .i_dest_port            (i_dest_port),
        .i_new_state            (i_new_state),
        .o_result_valid         (o_result_valid),
        .o_status               (o_status),
        .o_found                (o_found),
        .o_state_value          (o_state_value),
        .o_entry_source_address (o_entry_source_address),
        .o_entry_dest_address   (o_entry_dest_address),
        .o_entry_source_port    (o_entry_source_port),
        .o_entry_dest_port      (o_entry_dest_port),
        .o_table_count          (o_table_count),
        .o_last                 (o_last)
    );

`ifndef ASSERT_OFF
    // an accepted word always occupies the compare cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low in the cycle after a word was accepted");

    // dump results come back to back until the final one
    a_dump_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |=> o_result_valid)
        else $error("gap inside a dump sequence");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_table_count <= 7'(TABLE_DEPTH)))
        else $error("table count beyond depth");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == cttab_pkg::ST_FULL)) |->
        (o_table_count == 7'(TABLE_DEPTH)))
        else $error("insert dropped while table not full");
`endif

endmodule
